>>> rtl/fsfs_pkg.sv
// Package for the free segment fit search unit.
// Types, sizes and codes shared by fsfs_table and the top level; no dependencies.
package fsfs_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ADDR_BITS     = 16;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int START_W = (ADDR_BITS < 16) ? ADDR_BITS : 16;
    localparam int SIZE_W  = 16;

    localparam logic       KIND_WRITE  = 1'b0;
    localparam logic       KIND_SEARCH = 1'b1;

    localparam logic [1:0] STRAT_FIRST = 2'd0;
    localparam logic [1:0] STRAT_BEST  = 2'd1;
    localparam logic [1:0] STRAT_WORST = 2'd2;
    localparam logic [1:0] STRAT_NONE  = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [3:0]  entry_index;
        logic [15:0] entry_start;
        logic [15:0] entry_size;
        logic        entry_valid;
        logic [15:0] request_size;
        logic [1:0]  strategy;
    } t_fsfs_in;

    typedef struct packed {
        logic        found;
        logic [15:0] address;
    } t_fsfs_out;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
        logic               valid;
    } t_fsfs_wr;

    typedef struct packed {
        logic               valid;
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
    } t_fsfs_rd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_fsfs_state;

endpackage

>>> rtl/free_segment_fit_search_unit.sv
// Free segment fit search unit: top level with scan sequencer and output register.
// Depends on fsfs_pkg and fsfs_table.
//
// A write transaction loads one table entry in the cycle it is accepted and
// gives no result. A search transaction walks the table one entry per cycle
// through the single read port of the segment memories, then passes through the
// drain and finish states before its result enters the output register; no new
// transaction is taken during the walk.
// The output register lets the next transaction enter while a result waits.
module free_segment_fit_search_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fsfs_pkg::t_fsfs_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fsfs_pkg::t_fsfs_out o_out_data
);
    import fsfs_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_fsfs_state r_state, n_state;

    logic [IDX_W-1:0]   r_idx;
    logic [SIZE_W-1:0]  r_req;
    logic [1:0]         r_strat;
    logic               r_qual;
    logic               r_have;
    logic [SIZE_W-1:0]  r_left;
    logic [START_W-1:0] r_pick_start;
    logic               r_rd_vld;

    logic               r_out_vld;
    t_fsfs_out          r_out;

    t_fsfs_wr  wr;
    t_fsfs_rd  rd;
    logic      accept;
    logic      start_search;
    logic      rd_en;
    logic      load_out;
    logic      fit;
    logic      upd;
    logic [SIZE_W-1:0] left;

    assign accept       = i_in_valid && o_in_ready;
    assign start_search = accept && (i_in_data.kind == KIND_SEARCH);

    always_comb begin
        wr.en    = accept && (i_in_data.kind == KIND_WRITE)
                   && (32'(i_in_data.entry_index) < TABLE_ENTRIES);
        wr.idx   = IDX_W'(i_in_data.entry_index);
        wr.start = i_in_data.entry_start[START_W-1:0];
        wr.size  = i_in_data.entry_size;
        wr.valid = i_in_data.entry_valid;
    end

    fsfs_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_rd_en  (rd_en),
        .i_rd_idx (r_idx),
        .o_rd     (rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start_search) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        rd_en      = (r_state == ST_SCAN);
        load_out   = (r_state == ST_FINISH) && (!r_out_vld || i_out_ready);
    end

    assign fit  = r_rd_vld && r_qual && rd.valid && (rd.size >= r_req);
    assign left = rd.size - r_req;
    assign upd  = fit && (!r_have
                          || ((r_strat == STRAT_BEST) && (left < r_left))
                          || ((r_strat == STRAT_WORST) && (left > r_left)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_have    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (start_search) begin
                r_idx  <= '0;
                r_have <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (upd) begin
                    r_have <= 1'b1;
                end
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_search) begin
            r_req   <= i_in_data.request_size;
            r_strat <= i_in_data.strategy;
            r_qual  <= (i_in_data.request_size != '0) && (i_in_data.strategy != STRAT_NONE);
        end
        if (upd) begin
            r_left       <= left;
            r_pick_start <= rd.start;
        end
        if (load_out) begin
            r_out.found   <= r_have;
            r_out.address <= r_have ? 16'(r_pick_start) : 16'd0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> rtl/fsfs_table.sv
// Segment table: start and size memories with registered read, valid bits in flops.
// Depends on fsfs_pkg.
module fsfs_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  fsfs_pkg::t_fsfs_wr       i_wr,
    input  logic                     i_rd_en,
    input  logic [fsfs_pkg::IDX_W-1:0] i_rd_idx,
    output fsfs_pkg::t_fsfs_rd       o_rd
);
    import fsfs_pkg::*;

    logic [START_W-1:0] r_start_mem [TABLE_ENTRIES];
    logic [SIZE_W-1:0]  r_size_mem  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic [START_W-1:0] r_rd_start;
    logic [SIZE_W-1:0]  r_rd_size;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_start_mem[i_wr.idx] <= i_wr.start;
            r_size_mem[i_wr.idx]  <= i_wr.size;
        end
        if (i_rd_en) begin
            r_rd_start <= r_start_mem[i_rd_idx];
            r_rd_size  <= r_size_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.idx] <= i_wr.valid;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    assign o_rd.valid = r_rd_valid;
    assign o_rd.start = r_rd_start;
    assign o_rd.size  = r_rd_size;

endmodule

>>> sim/fsfs_checker.sv
`timescale 1ns / 100ps
// Checker for the free segment fit search unit: tracks the segment table from
// accepted write transactions, predicts each search result and compares it.
// Depends on fsfs_pkg.
module fsfs_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  fsfs_pkg::t_fsfs_in  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  fsfs_pkg::t_fsfs_out i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import fsfs_pkg::*;

    logic [START_W-1:0] seg_start [TABLE_ENTRIES];
    logic [SIZE_W-1:0]  seg_size  [TABLE_ENTRIES];
    logic               seg_free  [TABLE_ENTRIES];
    t_fsfs_out          fit_results_q [$];
    int                 fails = 0;

    function automatic t_fsfs_out predict_fit(logic [15:0] req, logic [1:0] strat);
        t_fsfs_out         res;
        logic              have;
        logic [SIZE_W-1:0] left;
        logic [SIZE_W-1:0] pick_left;
        int                pick;
        res       = '0;
        have      = 1'b0;
        pick      = 0;
        pick_left = '0;
        if (req != 16'd0 && strat != STRAT_NONE) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (seg_free[i] && seg_size[i] >= req && !(have && strat == STRAT_FIRST)) begin
                    left = seg_size[i] - req;
                    if (!have || (strat == STRAT_BEST && left < pick_left)
                              || (strat == STRAT_WORST && left > pick_left)) begin
                        have      = 1'b1;
                        pick      = i;
                        pick_left = left;
                    end
                end
            end
        end
        if (have) begin
            res.found   = 1'b1;
            res.address = 16'(seg_start[pick]);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_fsfs_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                seg_free[i] = 1'b0;
            end
            fit_results_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (fit_results_q.size() == 0) begin
                    $error("unexpected result transaction: found %0d, address %h",
                           i_out_data.found, i_out_data.address);
                    fails++;
                end else begin
                    want = fit_results_q.pop_front();
                    if (i_out_data.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, i_out_data.found);
                        fails++;
                    end
                    if (i_out_data.address !== want.address) begin
                        $error("address: expected %h, actual %h",
                               want.address, i_out_data.address);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.kind == KIND_WRITE) begin
                    if (int'(i_in_data.entry_index) < TABLE_ENTRIES) begin
                        seg_start[i_in_data.entry_index] = i_in_data.entry_start[START_W-1:0];
                        seg_size[i_in_data.entry_index]  = i_in_data.entry_size;
                        seg_free[i_in_data.entry_index]  = i_in_data.entry_valid;
                    end
                end else begin
                    fit_results_q.push_back(predict_fit(i_in_data.request_size,
                                                        i_in_data.strategy));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= fit_results_q.size();
    end

endmodule

>>> sim/free_segment_fit_search_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for free_segment_fit_search_unit: drives table writes and fit
// searches with random idling on both channels. Depends on fsfs_pkg, fsfs_checker.
module free_segment_fit_search_unit_tb;
    import fsfs_pkg::*;

    localparam int RANDOM_ITEMS   = 1780;
    localparam int HOLD_AFTER     = 500;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 60;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_fsfs_in  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_fsfs_out o_out_data;

    int          fail_count;
    int          pending;
    int          items_sent = 0;
    int          idle_cycles = 0;
    logic [15:0] size_shadow [16] = '{default: 16'd0};

    free_segment_fit_search_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    fsfs_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // unused fields carry random noise
    function automatic t_fsfs_in noise_item();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(t_fsfs_in)-1:0];
    endfunction

    task automatic send_item(input t_fsfs_in it);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        gap = pick_gap((items_sent / 128) % 4 == 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_entry(input logic [3:0] idx, input logic [15:0] start,
                               input logic [15:0] size, input logic vld);
        t_fsfs_in it;
        it             = noise_item();
        it.kind        = KIND_WRITE;
        it.entry_index = idx;
        it.entry_start = start;
        it.entry_size  = size;
        it.entry_valid = vld;
        size_shadow[idx] = size;
        send_item(it);
    endtask

    task automatic search_fit(input logic [15:0] req, input logic [1:0] strat);
        t_fsfs_in it;
        it              = noise_item();
        it.kind         = KIND_SEARCH;
        it.request_size = req;
        it.strategy     = strat;
        send_item(it);
    endtask

    initial begin : rx_proc
        int run;
        int gap;
        int rx_cycles;
        bit held;
        bit calm;
        rx_cycles = 0;
        held      = 1'b0;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held && items_sent >= HOLD_AFTER) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            calm = (rx_cycles / 256) % 4 == 1;
            run  = calm ? $urandom_range(20, 60) : $urandom_range(1, 8);
            i_out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            rx_cycles += run;
            gap = pick_gap(calm);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                rx_cycles += gap;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int          k;
        int          idx;
        logic [15:0] req;
        logic [15:0] size;
        logic [1:0]  strat;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, ties, invalid requests
        search_fit(16'd1, STRAT_FIRST);
        write_entry(4'd0, 16'h0000, 16'hFFFF, 1'b1);
        write_entry(4'd15, 16'hFFFF, 16'h0010, 1'b1);
        write_entry(4'd1, 16'h1234, 16'h0010, 1'b1);
        write_entry(4'd2, 16'hABCD, 16'h0000, 1'b1);
        write_entry(4'd3, 16'h5555, 16'h0100, 1'b0);
        write_entry(4'd4, 16'hAAAA, 16'hFFFF, 1'b1);
        search_fit(16'd1, STRAT_FIRST);
        search_fit(16'h0010, STRAT_BEST);
        search_fit(16'h0010, STRAT_WORST);
        search_fit(16'd0, STRAT_FIRST);
        search_fit(16'd5, STRAT_NONE);
        search_fit(16'hFFFF, STRAT_BEST);
        write_entry(4'd0, 16'hFFFF, 16'h0000, 1'b0);
        search_fit(16'hFFFF, STRAT_FIRST);
        search_fit(16'h0100, STRAT_BEST);
        write_entry(4'd4, 16'h0000, 16'hFFFF, 1'b0);
        search_fit(16'h0200, STRAT_WORST);
        search_fit(16'd1, STRAT_WORST);
        search_fit(16'd1, STRAT_BEST);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 40) begin
                k = $urandom_range(0, 9);
                if (k < 4) begin
                    size = 16'($urandom());
                end else if (k < 7) begin
                    size = 16'($urandom_range(1, 6) * 64);
                end else if (k < 9) begin
                    case ($urandom_range(0, 3))
                        0: size = 16'h0000;
                        1: size = 16'h0001;
                        2: size = 16'hFFFE;
                        default: size = 16'hFFFF;
                    endcase
                end else begin
                    size = 16'($urandom_range(0, 15));
                end
                write_entry(4'($urandom_range(0, 15)), 16'($urandom()), size,
                            $urandom_range(0, 9) < 8);
            end else begin
                k = $urandom_range(0, 9);
                if (k < 5) begin
                    idx = $urandom_range(0, 15);
                    req = size_shadow[idx] + 16'($urandom_range(0, 4)) - 16'd2;
                end else if (k < 7) begin
                    req = 16'($urandom());
                end else if (k == 7) begin
                    req = 16'd0;
                end else begin
                    req = 16'($urandom_range(1, 400));
                end
                k = $urandom_range(0, 9);
                strat = (k < 3) ? STRAT_FIRST : (k < 6) ? STRAT_BEST :
                        (k < 9) ? STRAT_WORST : STRAT_NONE;
                search_fit(req, strat);
            end
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
